// File: design/md5_cfb_byte_cipher_unit_assert.svh
// assertion macros for the md5 cfb byte cipher unit
`ifndef MD5_CFB_BYTE_CIPHER_UNIT_ASSERT_SVH
`define MD5_CFB_BYTE_CIPHER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MD5CFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("md5cfb check failed");
`define MD5CFB_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  `MD5CFB_ASSERT(lbl, clk, rst_n, !(prop))
`else
`define MD5CFB_ASSERT(lbl, clk, rst_n, prop)
`define MD5CFB_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// File: design/md5cfb_pkg.sv
`timescale 1ns / 1ps
package md5cfb_pkg;

  localparam logic [4:0] KEY_MAX_BYTES = 5'd16;
  localparam int unsigned BLOCK_BYTES = 16;

  typedef enum logic [1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2,
    CFG_DECRYPT  = 2'd3
  } cfg_index_e;

  typedef logic [BLOCK_BYTES-1:0][7:0] block_t;
  typedef logic [15:0][31:0] msg_t;
  typedef logic [3:0][31:0] chain_t;
  typedef logic [3:0] mod_tbl_t [256];

  localparam chain_t MD5_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // j mod n for n = 1..16, j = 0..15, indexed by {n-1, j}
  function automatic mod_tbl_t mod_tbl_init();
    mod_tbl_t tbl;
    logic [3:0] r;
    for (int n = 1; n <= 16; n++) begin
      r = 4'd0;
      for (int j = 0; j < 16; j++) begin
        tbl[(n - 1) * 16 + j] = r;
        r = (32'(r) + 1 == n) ? 4'd0 : r + 4'd1;
      end
    end
    return tbl;
  endfunction

  localparam mod_tbl_t KEY_MOD_TBL = mod_tbl_init();

  // single padded md5 block for a message of len bytes (1..16)
  function automatic msg_t build_msg(input block_t bytes, input logic [4:0] len);
    logic [19:0][7:0] blk;
    msg_t m;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < len) begin
        blk[i] = bytes[i];
      end else if (5'(i) == len) begin
        blk[i] = 8'h80;
      end else begin
        blk[i] = 8'h00;
      end
    end
    blk[16] = (len == 5'd16) ? 8'h80 : 8'h00;
    blk[17] = 8'h00;
    blk[18] = 8'h00;
    blk[19] = 8'h00;
    m = '0;
    for (int w = 0; w < 5; w++) begin
      m[w] = {blk[4*w+3], blk[4*w+2], blk[4*w+1], blk[4*w]};
    end
    m[14] = {24'h0, len, 3'b000};
    return m;
  endfunction

endpackage

// File: design/md5cfb_round.sv
`timescale 1ns / 1ps
module md5cfb_round
  import md5cfb_pkg::*;
(
  input  logic [5:0] round_i,
  input  chain_t     chain_i,
  input  msg_t       msg_i,
  output chain_t     chain_o
);

  logic [31:0] a, b, c, d, f, sum, rot;
  logic [3:0]  i4, g;
  logic [4:0]  s;

  assign a  = chain_i[0];
  assign b  = chain_i[1];
  assign c  = chain_i[2];
  assign d  = chain_i[3];
  assign i4 = round_i[3:0];
  assign s  = MD5_ROT[{round_i[5:4], round_i[1:0]}];

  always_comb begin
    unique case (round_i[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        g = i4;
      end
      2'd1: begin
        f = (d & b) | (~d & c);
        g = 4'(i4 * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = b ^ c ^ d;
        g = 4'(i4 * 4'd3 + 4'd5);
      end
      default: begin
        f = c ^ (b | ~d);
        g = 4'(i4 * 4'd7);
      end
    endcase
  end

  assign sum = a + f + MD5_K[round_i] + msg_i[g];
  assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));

  assign chain_o[0] = d;
  assign chain_o[1] = b + rot;
  assign chain_o[2] = b;
  assign chain_o[3] = c;

endmodule

// File: design/md5_cfb_byte_cipher_unit.sv
`timescale 1ns / 1ps
// md5 cipher-feedback byte cipher: one data byte per input transfer, one result byte per
// output transfer. one md5 round unit is shared across all 64 rounds, one round per cycle.
// a byte inside a 16-byte group is accepted, then emitted; the first byte of a group goes
// through load, 64 rounds, finish and emit; a start-of-message byte first computes md5 of
// the key (load, 64 rounds, finish) before the group pass. input ready is high only while
// the unit is idle; a finished byte waits in the output register so the next input may be
// taken meanwhile. the key is held in configuration registers, to be written only while
// idle by the user; the unit itself does not enforce this. cfg_ready_o is always high.
`include "md5_cfb_byte_cipher_unit_assert.svh"
module md5_cfb_byte_cipher_unit
  import md5cfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  result_byte_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_e;

  state_e      state_q;
  logic [63:0] key_lo_q, key_hi_q;
  logic [4:0]  key_len_q;
  logic        decrypt_q;

  logic [7:0]  data_q;
  logic        key_pass_q;      // current hash is md5 of the key
  logic [3:0]  pos_q;
  logic [5:0]  rnd_q;
  block_t      fb_q;            // feedback block
  chain_t      chain_q;
  msg_t        msg_q;
  logic        out_valid_q;
  logic [7:0]  out_q;

  logic [4:0]  klen;
  logic [3:0]  klen_m1;
  logic [127:0] key_all;
  block_t      key_blk, grp_blk;
  chain_t      chain_nxt;
  logic [7:0]  res;
  logic        in_xfer, emit_ok;

  // config register writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= 5'd1;
      decrypt_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LOW:  key_lo_q  <= cfg_data_i;
        CFG_KEY_HIGH: key_hi_q  <= cfg_data_i;
        CFG_KEY_LEN:  key_len_q <= cfg_data_i[4:0];
        default:      decrypt_q <= cfg_data_i[0];
      endcase
    end
  end

  // effective key length, zero counts as one, saturated at the max
  always_comb begin
    if (key_len_q == 5'd0) begin
      klen = 5'd1;
    end else if (key_len_q > KEY_MAX_BYTES) begin
      klen = KEY_MAX_BYTES;
    end else begin
      klen = key_len_q;
    end
  end
  assign klen_m1 = 4'(klen - 5'd1);
  assign key_all = {key_hi_q, key_lo_q};

  // message bytes for the key hash and for the group rehash
  always_comb begin
    for (int j = 0; j < BLOCK_BYTES; j++) begin
      key_blk[j] = key_all[8*j +: 8];
      grp_blk[j] = fb_q[j] ^ key_all[8*KEY_MOD_TBL[{klen_m1, 4'(j)}] +: 8];
    end
  end

  md5cfb_round u_round (
    .round_i (rnd_q),
    .chain_i (chain_q),
    .msg_i   (msg_q),
    .chain_o (chain_nxt)
  );

  assign in_ready_o    = (state_q == ST_IDLE);
  assign in_xfer       = in_valid_i && in_ready_o;
  assign emit_ok       = !out_valid_q || out_ready_i;
  assign res           = data_q ^ fb_q[pos_q];
  assign out_valid_o   = out_valid_q;
  assign result_byte_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      rnd_q       <= '0;
      key_pass_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (state_q == ST_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            data_q     <= data_byte_i;
            key_pass_q <= start_of_message_i;
            if (start_of_message_i || pos_q == 4'd0) begin
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_LOAD: begin
          msg_q   <= key_pass_q ? build_msg(key_blk, klen)
                                : build_msg(grp_blk, 5'(BLOCK_BYTES));
          chain_q <= MD5_IV;
          rnd_q   <= '0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          chain_q <= chain_nxt;
          rnd_q   <= rnd_q + 6'd1;   // wraps to zero after the last round
          if (rnd_q == 6'd63) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          for (int w = 0; w < 4; w++) begin
            {fb_q[4*w+3], fb_q[4*w+2], fb_q[4*w+1], fb_q[4*w]} <= MD5_IV[w] + chain_q[w];
          end
          if (key_pass_q) begin
            // key digest done, now rehash for the first group
            key_pass_q <= 1'b0;
            pos_q      <= '0;
            state_q    <= ST_LOAD;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        default: begin
          if (emit_ok) begin
            out_q       <= res;
            fb_q[pos_q] <= decrypt_q ? data_q : res;
            pos_q       <= pos_q + 4'd1;
            state_q     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  `MD5CFB_ASSERT(a_rnd_idle, clk_i, rst_ni, (state_q != ST_ROUND) |-> (rnd_q == 6'd0))
  `MD5CFB_ASSERT(a_busy_after_xfer, clk_i, rst_ni, in_xfer |=> !in_ready_o)
  `MD5CFB_ASSERT(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == ST_EMIT))
  `MD5CFB_ASSERT_NEVER(a_no_key_in_emit, clk_i, rst_ni, (state_q == ST_EMIT) && key_pass_q)

endmodule
